[hdl/cuac_pkg.sv]
// ---------------------------------------------------------------------------
// cuac_pkg
// Shared types and codes of the card access controller.
// ---------------------------------------------------------------------------
package cuac_pkg;

	localparam int UID_W             = 32;
	localparam int TABLE_ENTRIES_DEF = 16;

	localparam logic [15:0] DOOR_OPEN_MS_RST = 16'd5000;
	localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

	// request codes
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_LEARN  = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_CANCEL = 3'd3;
	localparam logic [2:0] REQ_CARD   = 3'd4;

	// result codes
	localparam logic [3:0] RC_NONE        = 4'd0;
	localparam logic [3:0] RC_GRANTED     = 4'd1;
	localparam logic [3:0] RC_DENIED      = 4'd2;
	localparam logic [3:0] RC_LEARNED     = 4'd3;
	localparam logic [3:0] RC_KNOWN       = 4'd4;
	localparam logic [3:0] RC_REMOVED     = 4'd5;
	localparam logic [3:0] RC_NOT_FOUND   = 4'd6;
	localparam logic [3:0] RC_FULL        = 4'd7;
	localparam logic [3:0] RC_AUTO_CLOSED = 4'd8;
	localparam logic [3:0] RC_ARMED       = 4'd9;

	// armed mode
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_LEARN  = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [UID_W-1:0] card_uid;
	} in_word_t;

	typedef struct packed {
		logic [3:0] result_code;
		logic       door_is_open;
	} out_word_t;

	// sequencer to search unit
	typedef struct packed {
		logic             start;
		logic [UID_W-1:0] uid;
	} match_req_t;

	// search unit to sequencer
	typedef struct packed {
		logic done;
		logic hit;
		logic free_found;
	} match_rsp_t;

endpackage

[hdl/cuac_ram.sv]
// ---------------------------------------------------------------------------
// cuac_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module cuac_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[hdl/cuac_match.sv]
// ---------------------------------------------------------------------------
// cuac_match
// Walks the UID table one entry a cycle through a single comparator and
// reports the first matching valid entry and the lowest free entry.
// ---------------------------------------------------------------------------
module cuac_match #(
	parameter int ENTRIES = cuac_pkg::TABLE_ENTRIES_DEF,
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cuac_pkg::match_req_t       req,
	input  logic [ENTRIES-1:0]         entry_valid,
	output logic                       rd_en,
	output logic [IDX_W-1:0]           rd_addr,
	input  logic [cuac_pkg::UID_W-1:0] rd_data,
	output cuac_pkg::match_rsp_t       rsp,
	output logic [IDX_W-1:0]           hit_idx,
	output logic [IDX_W-1:0]           free_idx
);

	import cuac_pkg::*;

	localparam int CNT_W = IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cmp_en_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             hit_q;
	logic             free_q;
	logic             done_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             is_hit;
	logic             is_free;

	assign rd_en   = run_q;
	assign rd_addr = cnt_q[IDX_W-1:0];

	assign is_hit  = cmp_en_s1 && entry_valid[cmp_idx_s1] && (rd_data == req.uid);
	assign is_free = cmp_en_s1 && !entry_valid[cmp_idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			cnt_q      <= '0;
			cmp_en_s1  <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			done_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
		end else begin
			done_q     <= cmp_en_s1 && (cmp_idx_s1 == LAST_IDX);
			cmp_en_s1  <= run_q;
			cmp_idx_s1 <= cnt_q[IDX_W-1:0];
			if (req.start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q[IDX_W-1:0] == LAST_IDX) begin
					run_q <= 1'b0;
				end
			end
			// keep only the first hit and the lowest free slot
			if (is_hit && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
			end
			if (is_free && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	assign rsp.done       = done_q;
	assign rsp.hit        = hit_q;
	assign rsp.free_found = free_q;
	assign hit_idx        = hit_idx_q;
	assign free_idx       = free_idx_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !run_q && !cmp_en_s1)
		else $error("search restarted while a walk is in progress");

	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q && !cmp_en_s1)
		else $error("walk reported done with entries still in flight");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && hit_q |-> entry_valid[hit_idx_q])
		else $error("reported hit on an invalid entry");

endmodule

[hdl/card_uid_access_controller_core.sv]
// ---------------------------------------------------------------------------
// card_uid_access_controller_core
// Door access controller: UID table, arming modes and auto-close timer.
// ---------------------------------------------------------------------------
// Tick, arm and cancel words commit on accept; their result goes through
// res_q to the output register. Card words walk the table one entry a cycle
// and commit when the walk ends, then take the same path. One word in
// flight; in_stall holds until its result is registered, longer while the
// output is stalled. Reset clears valid bits, mode, door, timer and open
// time (5000 ms); the UID store is not cleared.
module card_uid_access_controller_core #(
	parameter int TABLE_ENTRIES = cuac_pkg::TABLE_ENTRIES_DEF,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cuac_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output cuac_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	import cuac_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]               st_q;
	logic [UID_W-1:0]         uid_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [1:0]               mode_q;
	logic                     door_q;
	logic [15:0]              elapsed_q;
	logic [15:0]              open_ms_q;
	out_word_t                res_q;
	logic                     out_valid_q;
	out_word_t                out_data_q;

	logic                     in_acc;
	logic                     out_load;
	logic                     commit;
	logic                     wr_en;
	logic [TABLE_ENTRIES-1:0] valid_d;
	logic [1:0]               mode_d;
	logic                     door_d;
	logic [15:0]              elapsed_d;
	logic [3:0]               rc_d;
	logic [15:0]              elapsed_inc;

	match_req_t               m_req;
	match_rsp_t               m_rsp;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         free_idx;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic [UID_W-1:0]         rd_data;

	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_load  = (st_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign m_req.start = in_acc && (in_data.req_type == REQ_CARD);
	assign m_req.uid   = uid_q;

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

	// state update: non-card words commit on accept, cards when the walk ends
	always_comb begin
		commit    = 1'b0;
		wr_en     = 1'b0;
		valid_d   = valid_q;
		mode_d    = mode_q;
		door_d    = door_q;
		elapsed_d = elapsed_q;
		rc_d      = RC_NONE;
		if (in_acc && (in_data.req_type != REQ_CARD)) begin
			commit = 1'b1;
			case (in_data.req_type)
				REQ_TICK: begin
					if (door_q) begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc > open_ms_q) begin
							door_d = 1'b0;
							rc_d   = RC_AUTO_CLOSED;
						end
					end
				end
				REQ_LEARN: begin
					mode_d = MODE_LEARN;
					rc_d   = RC_ARMED;
				end
				REQ_REMOVE: begin
					mode_d = MODE_REMOVE;
					rc_d   = RC_ARMED;
				end
				REQ_CANCEL: begin
					mode_d = MODE_NORMAL;
				end
				default: begin
				end
			endcase
		end else if ((st_q == ST_WALK) && m_rsp.done) begin
			commit = 1'b1;
			mode_d = MODE_NORMAL;
			case (mode_q)
				MODE_LEARN: begin
					if (m_rsp.hit) begin
						rc_d = RC_KNOWN;
					end else if (m_rsp.free_found) begin
						wr_en             = 1'b1;
						valid_d[free_idx] = 1'b1;
						rc_d              = RC_LEARNED;
					end else begin
						rc_d = RC_FULL;
					end
				end
				MODE_REMOVE: begin
					if (m_rsp.hit) begin
						valid_d[hit_idx] = 1'b0;
						rc_d             = RC_REMOVED;
					end else begin
						rc_d = RC_NOT_FOUND;
					end
				end
				default: begin
					mode_d = mode_q;
					if (m_rsp.hit) begin
						door_d    = 1'b1;
						elapsed_d = '0;
						rc_d      = RC_GRANTED;
					end else begin
						rc_d = RC_DENIED;
					end
				end
			endcase
			// open time may have been shortened meanwhile
			if (door_d && (elapsed_d > open_ms_q)) begin
				door_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			valid_q     <= '0;
			mode_q      <= MODE_NORMAL;
			door_q      <= 1'b0;
			elapsed_q   <= '0;
			open_ms_q   <= DOOR_OPEN_MS_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				open_ms_q <= cfg_data;
			end
			if (commit) begin
				valid_q   <= valid_d;
				mode_q    <= mode_d;
				door_q    <= door_d;
				elapsed_q <= elapsed_d;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q <= (in_data.req_type == REQ_CARD) ? ST_WALK : ST_OUT;
					end
				end
				ST_WALK: begin
					if (m_rsp.done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			uid_q <= in_data.card_uid;
		end
		if (commit) begin
			res_q.result_code  <= rc_d;
			res_q.door_is_open <= door_d;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	cuac_match #(
		.ENTRIES (TABLE_ENTRIES)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (m_req),
		.entry_valid (valid_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.rsp         (m_rsp),
		.hit_idx     (hit_idx),
		.free_idx    (free_idx)
	);

	cuac_ram #(
		.WIDTH (UID_W),
		.DEPTH (TABLE_ENTRIES)
	) u_uid_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (free_idx),
		.wr_data (uid_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		m_rsp.done |-> st_q == ST_WALK)
		else $error("search finished outside a card walk");

	a_open_by_grant: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !door_q && door_d |-> rc_d == RC_GRANTED)
		else $error("door opened without a granted card");

	a_one_entry_change: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> $countones(valid_q ^ valid_d) <= 1)
		else $error("more than one table entry changed by one word");

	a_timer_idle_closed: assert property (@(posedge clk) disable iff (!arst_n)
		!door_q && commit && !door_d |-> elapsed_d == elapsed_q)
		else $error("open timer moved while the door was closed");

endmodule
